FILE: sv/top_k_hit_selector_top_macros.svh
// Assertion macros for the top-k hit selector checker.
// Needs clk and rst_n visible at the point of use.
`ifndef TOP_K_HIT_SELECTOR_TOP_MACROS_SVH
`define TOP_K_HIT_SELECTOR_TOP_MACROS_SVH

// same-cycle implication
`define TKS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TKS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/tks_pkg.sv
// Shared types, constants and ranking function for the top-k hit selector.
// No dependencies.
package tks_pkg;

  localparam int KEEP_COUNT_W = 7;
  localparam logic [KEEP_COUNT_W-1:0] KEEP_COUNT_RESET = 7'd64;
  localparam logic KIND_OFFER = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [31:0]       hit_id;
    logic signed [31:0] hit_score;
  } in_word_t;

  typedef struct packed {
    logic [31:0]       out_id;
    logic signed [31:0] out_score;
    logic              out_last;
  } out_word_t;

  typedef struct packed {
    logic [31:0]       id;
    logic signed [31:0] score;
  } hit_t;

  // control broadcast to every cell
  typedef struct packed {
    logic offer;  // insert the broadcast hit
    logic trunc;  // drop entries at or above the limit
    logic shift;  // move toward the head by one
  } cell_ctl_t;

  // a ranks strictly before b: higher score, then lower id
  function automatic logic ranks_before(hit_t a, hit_t b);
    ranks_before = (a.score > b.score) || ((a.score == b.score) && (a.id < b.id));
  endfunction

endpackage

FILE: sv/tks_cell.sv
// One slot of the sorted insertion chain.
// Depends on tks_pkg.
module tks_cell
  import tks_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  logic      allow,
  input  hit_t      new_hit,
  input  logic      prev_valid,
  input  hit_t      prev_hit,
  input  logic      prev_beat,
  input  logic      next_valid,
  input  hit_t      next_hit,
  output logic      valid,
  output hit_t      hit,
  output logic      beat
);

  logic valid_r, valid_nxt;
  hit_t hit_r, hit_nxt;

  // empty slot always loses to the new hit
  assign beat  = !valid_r || ranks_before(new_hit, hit_r);
  assign valid = valid_r;
  assign hit   = hit_r;

  always_comb begin
    valid_nxt = valid_r;
    hit_nxt   = hit_r;
    if (ctl.shift) begin
      valid_nxt = next_valid;
      hit_nxt   = next_hit;
    end else if (ctl.trunc) begin
      valid_nxt = valid_r & allow;
    end else if (ctl.offer) begin
      if (beat) begin
        if (prev_beat) begin
          valid_nxt = prev_valid;
          hit_nxt   = prev_hit;
        end else begin
          valid_nxt = 1'b1;
          hit_nxt   = new_hit;
        end
      end
      valid_nxt = valid_nxt & allow;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
  end

endmodule

FILE: sv/top_k_hit_selector_top.sv
// Top level of the top-k hit selector: control, limit register, output register.
// Depends on tks_pkg and tks_cell.
//
// Usage:
//  - Input channel (in_valid/in_ready/in_data): each word either offers a hit
//    (kind 0: id and signed Q16.16 score) or flushes (kind 1).
//  - Offers are accepted back to back; an offer never produces an output word.
//  - After a flush is accepted, the kept hits leave best first, one per
//    cycle while out_ready is high, out_last set on the final one.
//    in_ready stays low during the drain. A flush with nothing kept
//    emits nothing and returns to idle.
//  - The drain rate is set by the cell chain: the head cell feeds the
//    output register and every cell takes its neighbor's entry on each head load.
//  - Receiver stall: the output register holds its word; the chain pauses.
//  - cfg_we/cfg_wdata writes keep_count; write only while idle. Values
//    above CAPACITY act as CAPACITY.
//  - Reset (rst_n low, synchronous): store empty, keep_count = 64, idle.
module top_k_hit_selector_top
  import tks_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_word_t                in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_word_t               out_data,
  input  logic                    cfg_we,
  input  logic [KEEP_COUNT_W-1:0] cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t                  state_r, state_nxt;
  logic [KEEP_COUNT_W-1:0] keep_count_r;
  logic                    out_valid_r, out_valid_nxt;
  out_word_t               out_data_r, out_data_nxt;

  // chain taps; entry CAPACITY is the empty slot past the tail
  logic                    cell_valid [CAPACITY+1];
  hit_t                    cell_hit   [CAPACITY+1];
  logic                    cell_beat  [CAPACITY];

  logic      in_acc;
  logic      out_free;
  logic      head_load;
  cell_ctl_t ctl;
  hit_t      new_hit;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  // while draining, the head moves into the output register whenever there is room
  assign head_load = (state_r == ST_DRAIN) && cell_valid[0] && out_free;

  assign ctl.offer = in_acc && (in_data.kind == KIND_OFFER);
  assign ctl.trunc = in_acc && (in_data.kind == KIND_FLUSH);
  assign ctl.shift = head_load;

  assign new_hit.id    = in_data.hit_id;
  assign new_hit.score = in_data.hit_score;

  assign cell_valid[CAPACITY] = 1'b0;
  assign cell_hit[CAPACITY]   = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic allow;
    logic prev_valid;
    hit_t prev_hit;
    logic prev_beat;

    // slot i lies within the limit; i < CAPACITY holds already
    assign allow = keep_count_r > KEEP_COUNT_W'(i);

    if (i == 0) begin : g_head
      assign prev_valid = 1'b0;
      assign prev_hit   = '0;
      assign prev_beat  = 1'b0;
    end else begin : g_body
      assign prev_valid = cell_valid[i-1];
      assign prev_hit   = cell_hit[i-1];
      assign prev_beat  = cell_beat[i-1];
    end

    tks_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .allow     (allow),
      .new_hit   (new_hit),
      .prev_valid(prev_valid),
      .prev_hit  (prev_hit),
      .prev_beat (prev_beat),
      .next_valid(cell_valid[i+1]),
      .next_hit  (cell_hit[i+1]),
      .valid     (cell_valid[i]),
      .hit       (cell_hit[i]),
      .beat      (cell_beat[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (ctl.trunc) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // chain empty: last word already handed to the output register
        if (!cell_valid[0]) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (head_load) begin
      out_data_nxt.out_id    = cell_hit[0].id;
      out_data_nxt.out_score = cell_hit[0].score;
      out_data_nxt.out_last  = !cell_valid[1];
      out_valid_nxt          = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      keep_count_r <= KEEP_COUNT_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        keep_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: sv/tks_checker.sv
// Port-level checker for the top-k hit selector, bound to the top level.
// Depends on tks_pkg and top_k_hit_selector_top_macros.svh.
`include "top_k_hit_selector_top_macros.svh"

module tks_checker
  import tks_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  `TKS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled output word changed")
  `TKS_ASSERT_NOW(a_busy_mid_run, out_valid && !out_data.out_last, !in_ready, "input taken during a flush run")
  `TKS_ASSERT_NEXT(a_flush_busy, in_valid && in_ready && (in_data.kind == KIND_FLUSH), !in_ready, "flush did not block input")
  `TKS_ASSERT_NEXT(a_offer_silent, in_valid && in_ready && (in_data.kind == KIND_OFFER) && !out_valid, !out_valid, "offer produced an output word")

endmodule

bind top_k_hit_selector_top tks_checker u_tks_checker (.*);
